// ===== src/cnv_pkg.sv =====
package cnv_pkg;

    localparam int KERNEL_DEF    = 7;
    localparam int IN_CH_DEF     = 7;
    localparam int OUT_CH_DEF    = 16;
    localparam int MAX_WIDTH_DEF = 256;
    localparam int MAX_HEIGHT    = 4096;

    localparam int OPCODE_W   = 1;
    localparam int WIDX_W     = 13;
    localparam int DATA_W     = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 8;
    localparam int OCH_W      = 4;
    localparam int VAL_W      = 24;
    localparam int ACC_W      = 32;
    localparam int IMG_W_W    = 9;
    localparam int IMG_H_W    = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [OPCODE_W-1:0] OP_WEIGHT = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 9'd64;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd64;

endpackage

// ===== src/cnv_if.sv =====
interface cnv_in_if;
    import cnv_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [WIDX_W-1:0]   weight_index;
    logic signed [DATA_W-1:0] weight_value;
    logic signed [DATA_W-1:0] sample;

    modport source (output valid, opcode, weight_index, weight_value, sample, input ready);
    modport sink   (input valid, opcode, weight_index, weight_value, sample, output ready);
endinterface

interface cnv_out_if;
    import cnv_pkg::*;

    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;
    logic [OCH_W-1:0]   out_channel;
    logic signed [VAL_W-1:0] out_value;
    logic               last;

    modport source (output valid, out_row, out_col, out_channel, out_value, last, input ready);
    modport sink   (input valid, out_row, out_col, out_channel, out_value, last, output ready);
endinterface

// ===== src/int8_conv2d_7x7_multichannel.sv =====
// Weight transfers and samples that close no window are taken while idle.
// A sample closing a window starts KERNEL*KERNEL*IN_CH multiply-accumulates for
// each of the OUT_CH channels, one per cycle while running through the single
// shared MAC and one read of each RAM per cycle; no items are taken until done.
// Reset: counters to zero, image size to 64x64, RAM contents left undefined.
module int8_conv2d_7x7_multichannel #(
    parameter int KERNEL    = cnv_pkg::KERNEL_DEF,
    parameter int IN_CH     = cnv_pkg::IN_CH_DEF,
    parameter int OUT_CH    = cnv_pkg::OUT_CH_DEF,
    parameter int MAX_WIDTH = cnv_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cnv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cnv_pkg::CFG_DATA_W-1:0]    cfg_data,
    cnv_in_if.sink                            items,
    cnv_out_if.source                         results
);
    import cnv_pkg::*;

    localparam int TAPS = KERNEL * KERNEL * IN_CH;
    localparam int WD   = TAPS * OUT_CH;
    localparam int LD   = KERNEL * MAX_WIDTH * IN_CH;
    localparam int WAW  = $clog2(WD);
    localparam int LAW  = $clog2(LD);
    localparam int TW   = $clog2(TAPS + 1);
    localparam int PW   = $clog2(KERNEL * IN_CH + 1);
    localparam int SW   = $clog2(KERNEL + 1);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CHW  = $clog2(IN_CH + 1);
    localparam int OCW  = $clog2(OUT_CH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [IMG_W_W-1:0] img_w_reg;
    logic [IMG_H_W-1:0] img_h_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [CW-1:0]      col_reg;
    logic [CHW-1:0]     chan_reg;
    logic [SW-1:0]      wslot_reg;

    logic [ROW_W-1:0]   top_reg;
    logic [CW-1:0]      left_reg;
    logic [LAW-1:0]     leftic_reg;
    logic [SW-1:0]      rslot0_reg;
    logic [SW-1:0]      rslot_reg;
    logic [PW-1:0]      pos_reg;
    logic [TW-1:0]      t_reg;
    logic [WAW-1:0]     waddr_reg;
    logic [OCW-1:0]     och_reg;
    logic               rd_valid_reg;

    logic               ov_reg;
    logic [ROW_W-1:0]   o_row_reg;
    logic [COL_W-1:0]   o_col_reg;
    logic [OCH_W-1:0]   o_och_reg;
    logic [VAL_W-1:0]   o_val_reg;
    logic               o_last_reg;

    logic [31:0]        w_use;
    logic [31:0]        h_use;
    logic               acc_in;
    logic               w_we;
    logic               l_we;
    logic               start;
    logic               issue;
    logic               ld;
    logic               och_last;
    logic               clr;
    logic               mac_busy;
    logic [VAL_W-1:0]   mac_res;
    logic [31:0]        widx32;
    logic [31:0]        lw32;
    logic [31:0]        lr32;
    logic [SW-1:0]      wslot_inc;
    logic [DATA_W-1:0]  w_rdata;
    logic [DATA_W-1:0]  l_rdata;

    assign items.ready = (state_reg == S_IDLE);
    assign acc_in      = items.valid && items.ready;
    assign widx32      = 32'(items.weight_index);
    assign w_we        = acc_in && (items.opcode == OP_WEIGHT) && (widx32 < 32'(WD));
    assign l_we        = acc_in && (items.opcode == OP_SAMPLE);
    assign start       = l_we && (32'(chan_reg) + 32'd1 >= 32'(IN_CH))
                         && (32'(row_reg) >= 32'(KERNEL - 1))
                         && (32'(col_reg) >= 32'(KERNEL - 1));
    assign issue       = (state_reg == S_RUN);
    assign och_last    = (och_reg == OCW'(OUT_CH - 1));
    assign ld          = (state_reg == S_EMIT) && (!ov_reg || results.ready);
    assign clr         = start || (ld && !och_last);
    assign wslot_inc   = (wslot_reg == SW'(KERNEL - 1)) ? '0 : SW'(wslot_reg + 1'b1);

    assign w_use = (img_w_reg == '0) ? 32'd1 :
                   ((32'(img_w_reg) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(img_w_reg));
    assign h_use = (img_h_reg == '0) ? 32'd1 :
                   ((32'(img_h_reg) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(img_h_reg));

    assign lw32 = 32'(wslot_reg) * 32'(MAX_WIDTH * IN_CH) + 32'(col_reg) * 32'(IN_CH)
                  + 32'(chan_reg);
    assign lr32 = 32'(rslot_reg) * 32'(MAX_WIDTH * IN_CH) + 32'(leftic_reg) + 32'(pos_reg);

    cnv_ram #(.DEPTH(WD), .WIDTH(DATA_W)) u_wram (
        .clk   (clk),
        .we    (w_we),
        .waddr (widx32[WAW-1:0]),
        .wdata (items.weight_value),
        .raddr (waddr_reg),
        .rdata (w_rdata)
    );

    cnv_ram #(.DEPTH(LD), .WIDTH(DATA_W)) u_lram (
        .clk   (clk),
        .we    (l_we),
        .waddr (lw32[LAW-1:0]),
        .wdata (items.sample),
        .raddr (lr32[LAW-1:0]),
        .rdata (l_rdata)
    );

    cnv_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (clr),
        .in_valid (rd_valid_reg),
        .a        (l_rdata),
        .b        (w_rdata),
        .busy     (mac_busy),
        .result   (mac_res)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (t_reg == TW'(TAPS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg && !mac_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (ld)
                begin
                    state_next = och_last ? S_IDLE : S_RUN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            img_w_reg    <= IMAGE_WIDTH_RST;
            img_h_reg    <= IMAGE_HEIGHT_RST;
            row_reg      <= '0;
            col_reg      <= '0;
            chan_reg     <= '0;
            wslot_reg    <= '0;
            rd_valid_reg <= 1'b0;
            ov_reg       <= 1'b0;
            och_reg      <= '0;
            t_reg        <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue;

            if (ld)
            begin
                ov_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                ov_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                if (cfg_index == CFG_IMAGE_WIDTH)
                begin
                    img_w_reg <= cfg_data[IMG_W_W-1:0];
                end
                else
                begin
                    img_h_reg <= cfg_data[IMG_H_W-1:0];
                end
                row_reg   <= '0;
                col_reg   <= '0;
                chan_reg  <= '0;
                wslot_reg <= '0;
            end
            else if (l_we)
            begin
                if (32'(chan_reg) + 32'd1 < 32'(IN_CH))
                begin
                    chan_reg <= CHW'(chan_reg + 1'b1);
                end
                else
                begin
                    chan_reg <= '0;
                    if (32'(col_reg) + 32'd1 >= w_use)
                    begin
                        col_reg <= '0;
                        if (32'(row_reg) + 32'd1 >= h_use)
                        begin
                            row_reg   <= '0;
                            wslot_reg <= '0;
                        end
                        else
                        begin
                            row_reg   <= ROW_W'(row_reg + 1'b1);
                            wslot_reg <= wslot_inc;
                        end
                    end
                    else
                    begin
                        col_reg <= CW'(col_reg + 1'b1);
                    end
                end
            end

            if (start)
            begin
                och_reg <= '0;
                t_reg   <= '0;
                pos_reg <= '0;
            end
            else if (issue)
            begin
                t_reg <= TW'(t_reg + 1'b1);
                if (pos_reg == PW'(KERNEL * IN_CH - 1))
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= PW'(pos_reg + 1'b1);
                end
            end
            else if (ld && !och_last)
            begin
                och_reg <= OCW'(och_reg + 1'b1);
                t_reg   <= '0;
                pos_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            top_reg    <= ROW_W'(row_reg - ROW_W'(KERNEL - 1));
            left_reg   <= CW'(col_reg - CW'(KERNEL - 1));
            leftic_reg <= LAW'((32'(col_reg) - 32'(KERNEL - 1)) * 32'(IN_CH));
            rslot0_reg <= wslot_inc;
            rslot_reg  <= wslot_inc;
            waddr_reg  <= '0;
        end
        else if (issue)
        begin
            waddr_reg <= WAW'(32'(waddr_reg) + 32'(OUT_CH));
            if (pos_reg == PW'(KERNEL * IN_CH - 1))
            begin
                rslot_reg <= (rslot_reg == SW'(KERNEL - 1)) ? '0 : SW'(rslot_reg + 1'b1);
            end
        end
        else if (ld && !och_last)
        begin
            rslot_reg <= rslot0_reg;
            waddr_reg <= WAW'(och_reg + 1'b1);
        end

        if (ld)
        begin
            o_row_reg  <= top_reg;
            o_col_reg  <= COL_W'(32'(left_reg));
            o_och_reg  <= OCH_W'(och_reg);
            o_val_reg  <= mac_res;
            o_last_reg <= och_last;
        end
    end

    assign results.valid       = ov_reg;
    assign results.out_row     = o_row_reg;
    assign results.out_col     = o_col_reg;
    assign results.out_channel = o_och_reg;
    assign results.out_value   = o_val_reg;
    assign results.last        = o_last_reg;

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !items.ready)
        else $error("input ready while computing");

    a_read_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == S_RUN))
        else $error("read data without an issue");

    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ld && och_last) |=> (results.valid && results.last))
        else $error("final channel not marked");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (row_reg == '0 && col_reg == '0 && chan_reg == '0))
        else $error("counters not restarted on register write");

    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ld |-> (!mac_busy && !rd_valid_reg))
        else $error("result loaded before accumulation finished");
endmodule

// ===== src/cnv_ram.sv =====
module cnv_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/cnv_mac.sv =====
module cnv_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clear,
    input  logic                                in_valid,
    input  logic signed [cnv_pkg::DATA_W-1:0]   a,
    input  logic signed [cnv_pkg::DATA_W-1:0]   b,
    output logic                                busy,
    output logic signed [cnv_pkg::VAL_W-1:0]    result
);
    import cnv_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2 ** (VAL_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(2 ** (VAL_W - 1));

    logic signed [2*DATA_W-1:0] prod_reg;
    logic                       pv_reg;
    logic signed [ACC_W-1:0]    acc_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= a * b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            pv_reg <= in_valid;
            if (clear)
            begin
                acc_reg <= '0;
            end
            else if (pv_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    always_comb
    begin
        if (acc_reg > SAT_MAX)
        begin
            result = SAT_MAX[VAL_W-1:0];
        end
        else if (acc_reg < SAT_MIN)
        begin
            result = SAT_MIN[VAL_W-1:0];
        end
        else
        begin
            result = acc_reg[VAL_W-1:0];
        end
    end

    assign busy = pv_reg;
endmodule
